>>> hdl/tdpc_pkg.sv
// shared types and constants for the trial division prime check block
package tdpc_pkg;

  // fixed field widths
  localparam int DATA_W         = 64;
  localparam int HALF_W         = DATA_W / 2;
  localparam int STORED_COUNT_W = 11;
  localparam int REM_CNT_W      = $clog2(DATA_W + 1);

  // function codes of an input word
  localparam logic FUNC_CHECK  = 1'b0;
  localparam logic FUNC_APPEND = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_CMP,
    ST_DIV,
    ST_DONE
  } tdpc_state_t;

  // status of the remainder unit
  typedef struct packed {
    logic done;
    logic rem_zero;
  } tdpc_rem_stat_t;

endpackage

>>> hdl/tdpc_if.sv
// valid/ready channel interfaces for input and result words
interface tdpc_in_if;
  import tdpc_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [DATA_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface tdpc_out_if;
  import tdpc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      prime_flag;
  logic                      table_full;
  logic [STORED_COUNT_W-1:0] stored_count;

  modport source (output valid, output prime_flag, output table_full, output stored_count,
                  input ready);
  modport sink   (input valid, input prime_flag, input table_full, input stored_count,
                  output ready);
endinterface

>>> hdl/tdpc_table.sv
// single port write, single port read prime table memory with registered read
module tdpc_table #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [ADDR_W-1:0]              wr_addr,
  input  logic [tdpc_pkg::DATA_W-1:0]    wr_data,
  input  logic                           rd_en,
  input  logic [ADDR_W-1:0]              rd_addr,
  output logic [tdpc_pkg::DATA_W-1:0]    rd_data
);
  import tdpc_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/tdpc_rem_unit.sv
// iterative restoring remainder unit, one quotient bit per cycle
module tdpc_rem_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tdpc_pkg::DATA_W-1:0] dividend,
  input  logic [tdpc_pkg::DATA_W-1:0] divisor,
  output tdpc_pkg::tdpc_rem_stat_t    stat
);
  import tdpc_pkg::*;

  logic [DATA_W-1:0]    n_r, n_nxt;
  logic [DATA_W-1:0]    d_r, d_nxt;
  logic [DATA_W-1:0]    r_r, r_nxt;
  logic [REM_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DATA_W:0]      trial;
  logic [DATA_W+1:0]    diff;

  // one shift and trial subtract per cycle
  always_comb begin
    trial    = {r_r, n_r[DATA_W-1]};
    diff     = {1'b0, trial} - {2'b00, d_r};
    n_nxt    = n_r;
    d_nxt    = d_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt    = dividend;
      d_nxt    = divisor;
      r_nxt    = '0;
      cnt_nxt  = REM_CNT_W'(DATA_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt   = {n_r[DATA_W-2:0], 1'b0};
      // no borrow means trial >= divisor
      r_nxt   = diff[DATA_W+1] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == REM_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    d_r <= d_nxt;
    r_r <= r_nxt;
  end

  assign stat.done     = done_r;
  assign stat.rem_zero = (r_r == '0);

  // a new division never starts over a running one
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("remainder unit restarted while busy");

  // done follows the last iteration
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("remainder done without a running division");

  // iteration count stays live while running
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("remainder unit running with no iterations left");

endmodule

>>> hdl/trial_division_prime_check_core.sv
// top level: trial division primality checker with an append-only prime table
//
// Input channel in_chan carries func and a 64-bit value. func = check tests the
// value against the stored entries in table order; func = append stores the
// value at the next free slot. Each input word yields one result word on
// out_chan: prime_flag, table_full and the stored count after the word.
// The block takes one word at a time and is not ready while it works.
// An append goes straight from accept to its result. A check fetches, loads
// and compares each stored entry in table order: a zero entry is skipped, an
// entry whose square exceeds the value ends the check, and any other entry is
// divided into the value by the shared remainder unit, which also ends the
// check on a zero remainder. The result sits in an output register: the next
// input word is accepted while an earlier result still waits, and a finished
// check waits in place while the receiver stalls with the register full.
// Synchronous active-low reset empties the table count and drops any pending
// result; table contents are not cleared, only entries below the count are read.
module trial_division_prime_check_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input logic         clk,
  input logic         rst_n,
  tdpc_in_if.sink     in_chan,
  tdpc_out_if.source  out_chan
);
  import tdpc_pkg::*;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  tdpc_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     idx_inc;
  logic [DATA_W-1:0]    value_r, value_nxt;
  logic [DATA_W-1:0]    p_r, p_nxt;
  logic [DATA_W-1:0]    sq_r, sq_nxt;
  logic                 p_big_r, p_big_nxt;
  logic                 res_prime_r, res_prime_nxt;
  logic                 res_full_r, res_full_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_prime_r;
  logic                 out_full_r;
  logic [STORED_COUNT_W-1:0] out_count_r;
  logic [CNT_W+STORED_COUNT_W-1:0] cnt_ext;

  logic                 in_acc;
  logic                 out_free;
  logic                 out_load;
  logic                 last_entry;
  logic                 sq_exceeds;
  logic                 wr_en;
  logic                 rd_en;
  logic                 rem_start;
  logic [DATA_W-1:0]    rd_data;
  tdpc_rem_stat_t       rem_stat;

  assign in_acc     = (state_r == ST_IDLE) && in_chan.valid;
  assign out_free   = !out_valid_r || out_chan.ready;
  assign idx_inc    = idx_r + 1'b1;
  assign last_entry = (idx_inc == cnt_r);
  assign sq_exceeds = p_big_r || (sq_r > value_r);
  assign cnt_ext    = {{STORED_COUNT_W{1'b0}}, cnt_r};

  // prime table memory
  tdpc_table #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (in_chan.value),
    .rd_en   (rd_en),
    .rd_addr (idx_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // shared remainder unit
  tdpc_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (value_r),
    .divisor  (p_r),
    .stat     (rem_stat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.func == FUNC_APPEND || cnt_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_CMP;
      ST_CMP: begin
        if (p_r == '0) begin
          state_nxt = last_entry ? ST_DONE : ST_FETCH;
        end else if (sq_exceeds) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.rem_zero || last_entry) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    in_chan.ready = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rem_start     = 1'b0;
    out_load      = 1'b0;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    value_nxt     = value_r;
    p_nxt         = p_r;
    sq_nxt        = sq_r;
    p_big_nxt     = p_big_r;
    res_prime_nxt = res_prime_r;
    res_full_nxt  = res_full_r;
    unique case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_acc) begin
          value_nxt     = in_chan.value;
          idx_nxt       = '0;
          res_prime_nxt = (in_chan.func == FUNC_CHECK);
          res_full_nxt  = 1'b0;
          if (in_chan.func == FUNC_APPEND) begin
            if (cnt_r < DEPTH_C) begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              res_full_nxt = 1'b1;
            end
          end
        end
      end
      ST_FETCH: rd_en = 1'b1;
      ST_LOAD: begin
        // square of the low half; a nonzero high half always exceeds
        p_nxt     = rd_data;
        p_big_nxt = |rd_data[DATA_W-1:HALF_W];
        sq_nxt    = rd_data[HALF_W-1:0] * rd_data[HALF_W-1:0];
      end
      ST_CMP: begin
        if (p_r == '0) begin
          idx_nxt = idx_inc;
        end else if (!sq_exceeds) begin
          rem_start = 1'b1;
        end
      end
      ST_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.rem_zero) begin
            res_prime_nxt = 1'b0;
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath and result words
  always_ff @(posedge clk) begin
    value_r     <= value_nxt;
    p_r         <= p_nxt;
    sq_r        <= sq_nxt;
    p_big_r     <= p_big_nxt;
    res_prime_r <= res_prime_nxt;
    res_full_r  <= res_full_nxt;
    if (out_load) begin
      out_prime_r <= res_prime_r;
      out_full_r  <= res_full_r;
      out_count_r <= cnt_ext[STORED_COUNT_W-1:0];
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.prime_flag   = out_prime_r;
  assign out_chan.table_full   = out_full_r;
  assign out_chan.stored_count = out_count_r;

  // count never runs past the table
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count beyond table depth");

  // a division is only started on a nonzero entry that passed the square test
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    rem_start |-> (p_r != '0) && !p_big_r && (state_r == ST_CMP))
    else $error("remainder started on an invalid divisor");

  // a dropped append is reported only with a full table
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res_full_r |-> cnt_r == DEPTH_C && !res_prime_r)
    else $error("table full flag with free entries");

endmodule
